// ===== design/rgb_led_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_pkg
// Shared codes, widths and reset values for the rgb led fade/mode controller.
// ----------------------------------------------------------------------------
package rgb_led_pkg;

    localparam int LevelW  = 8;
    localparam int LightW  = 10;
    localparam int ModeW   = 3;
    localparam int NibW    = 4;
    localparam int ColourW = 3;
    localparam int MinuteW = 5;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 10;

    typedef enum logic [1:0] {
        ACT_COMMAND = 2'd0,
        ACT_FADE    = 2'd1,
        ACT_MINUTE  = 2'd2,
        ACT_UNUSED  = 2'd3
    } t_action;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FADE_TOP    = 2'd0,
        CFG_FADE_BOTTOM = 2'd1,
        CFG_DARK_THR    = 2'd2,
        CFG_NONE        = 2'd3
    } t_cfg_index;

    localparam logic [ModeW-1:0] MODE_PATTERN = 3'd0;
    localparam logic [ModeW-1:0] MODE_RED     = 3'd1;
    localparam logic [ModeW-1:0] MODE_GREEN   = 3'd2;
    localparam logic [ModeW-1:0] MODE_BLUE    = 3'd3;
    localparam logic [ModeW-1:0] MODE_TIMER   = 3'd4;
    localparam logic [ModeW-1:0] MODE_SLEEP   = 3'd5;
    localparam logic [ModeW-1:0] MODE_SENSOR  = 3'd6;
    localparam logic [NibW-1:0]  MODE_MAX_NIB = 4'd6;

    localparam logic [NibW-1:0]    PAT_CYCLE     = 4'd9;
    localparam logic [NibW-1:0]    PAT_LAST_FIX  = 4'd8;
    localparam logic [ColourW-1:0] COLOUR_WHITE  = 3'd7;
    localparam logic [LevelW-1:0]  LEVEL_MAX     = 8'd255;
    localparam logic [MinuteW:0]   MINUTE_WRAP   = 6'd17;

    localparam logic [LevelW-1:0] RST_FADE_TOP    = 8'd200;
    localparam logic [LevelW-1:0] RST_FADE_BOTTOM = 8'd1;
    localparam logic [LightW-1:0] RST_DARK_THR    = 10'd400;
    localparam logic [ModeW-1:0]  RST_MODE        = 3'd1;
    localparam logic [NibW-1:0]   RST_PATTERN     = 4'd9;

endpackage

// ===== design/rgb_led_fade_mode_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_fade_mode_controller
// Mode/command decoder, color fade ramp and minute timer for an rgb led.
//
//   channel | dir | fields (low bit first)
//   s_axis  | in  | tdata: command_byte[7:0], light_level[17:8]; tuser: action
//   m_axis  | out | tdata: red[7:0], green[15:8], blue[23:16], off[24], mode[27:25]
//   cfg     | in  | index: 0 fade_top, 1 fade_bottom, 2 dark_threshold; data
//
// one request per cycle unless a stalled result holds the pipe; a request passes through
// the input register, then the result register after one pass of update logic
// synchronous active-low reset clears both stages and restores register values
// a stalled result holds the result register; input register still fills once
// cfg channel is always ready
// ----------------------------------------------------------------------------
module rgb_led_fade_mode_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // command_byte, light_level, pad
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red, green, blue, lights_off, mode, pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    localparam int LW = rgb_led_pkg::LevelW;
    localparam int TW = rgb_led_pkg::LightW;
    localparam int MW = rgb_led_pkg::ModeW;
    localparam int NW = rgb_led_pkg::NibW;
    localparam int CW = rgb_led_pkg::ColourW;
    localparam int UW = rgb_led_pkg::MinuteW;

    // config registers
    logic [LW-1:0] r_fade_top, r_fade_bottom;
    logic [TW-1:0] r_dark_thr;

    // pipeline
    logic          r_in_valid, r_out_valid;
    logic [1:0]    r_in_action;
    logic [7:0]    r_in_cmd;
    logic [TW-1:0] r_in_light;
    logic [31:0]   r_out_data;
    logic          out_free, advance;

    // state
    logic [MW-1:0] r_mode, n_mode;
    logic [NW-1:0] r_pattern, n_pattern;
    logic [CW-1:0] r_colour, n_colour;
    logic          r_falling, n_falling;
    logic [LW-1:0] r_fade, n_fade;
    logic [LW-1:0] r_red, n_red, r_green, n_green, r_blue, n_blue;
    logic [NW-1:0] r_limit, n_limit;
    logic [UW-1:0] r_count, n_count;

    logic          bright, off, fade_en;
    logic [NW-1:0] nib, arg;
    logic [LW-1:0] lvl;
    logic [UW:0]   count_inc;
    logic [NW-1:0] colour_next;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign bright      = r_in_light > r_dark_thr;
    assign nib         = r_in_cmd[7:4];
    assign arg         = r_in_cmd[3:0];
    assign count_inc   = {1'b0, r_count} + {{UW{1'b0}}, 1'b1};
    assign colour_next = {1'b0, r_colour} + {{(NW-1){1'b0}}, 1'b1};
    assign fade_en     = (r_mode == rgb_led_pkg::MODE_PATTERN)
                      || (r_mode == rgb_led_pkg::MODE_SLEEP)
                      || (r_mode == rgb_led_pkg::MODE_SENSOR && !bright);

    always_comb begin
        n_mode    = r_mode;
        n_pattern = r_pattern;
        n_colour  = r_colour;
        n_falling = r_falling;
        n_fade    = r_fade;
        n_red     = r_red;
        n_green   = r_green;
        n_blue    = r_blue;
        n_limit   = r_limit;
        n_count   = r_count;
        lvl       = r_fade;
        off       = 1'b0;

        case (rgb_led_pkg::t_action'(r_in_action))
            rgb_led_pkg::ACT_COMMAND: begin
                if (nib > rgb_led_pkg::MODE_MAX_NIB) begin
                    n_mode = rgb_led_pkg::MODE_PATTERN;
                end else begin
                    n_mode = nib[MW-1:0];
                    case (nib[MW-1:0])
                        rgb_led_pkg::MODE_PATTERN: begin
                            n_pattern = arg;
                            if (arg >= 4'd1 && arg <= rgb_led_pkg::PAT_LAST_FIX) begin
                                n_colour = CW'(arg - 4'd1);
                            end else if (arg == rgb_led_pkg::PAT_CYCLE) begin
                                n_colour = '0;
                            end
                        end
                        rgb_led_pkg::MODE_RED:   n_red   = {{(LW-NW){1'b0}}, arg};
                        rgb_led_pkg::MODE_GREEN: n_green = {{(LW-NW){1'b0}}, arg};
                        rgb_led_pkg::MODE_BLUE:  n_blue  = {{(LW-NW){1'b0}}, arg};
                        rgb_led_pkg::MODE_TIMER, rgb_led_pkg::MODE_SLEEP: begin
                            n_limit = arg;
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            rgb_led_pkg::ACT_FADE: begin
                if (fade_en) begin
                    if (!r_falling) begin
                        lvl = (r_fade < rgb_led_pkg::LEVEL_MAX) ? r_fade + 8'd1 : r_fade;
                    end else begin
                        lvl = (r_fade > '0) ? r_fade - 8'd1 : r_fade;
                    end
                    n_fade = lvl;
                    // paint current color
                    n_red   = '0;
                    n_green = '0;
                    n_blue  = '0;
                    case (r_colour)
                        3'd0: n_red = lvl;
                        3'd1: begin n_red = lvl; n_green = lvl >> 1; end
                        3'd2: begin n_red = lvl; n_green = lvl; end
                        3'd3: n_green = lvl;
                        3'd4: begin n_green = lvl; n_blue = lvl; end
                        3'd5: n_blue = lvl;
                        3'd6: begin n_red = lvl; n_blue = lvl; end
                        default: begin n_red = lvl; n_green = lvl; n_blue = lvl; end
                    endcase
                    if (!r_falling) begin
                        if (lvl >= r_fade_top) n_falling = 1'b1;
                    end else if (lvl <= r_fade_bottom) begin
                        n_falling = 1'b0;
                        n_fade    = '0;
                        if (r_pattern == colour_next) begin
                            n_colour = r_colour;
                        end else if (r_pattern == rgb_led_pkg::PAT_CYCLE) begin
                            n_colour = colour_next[CW-1:0];
                        end else begin
                            n_colour = rgb_led_pkg::COLOUR_WHITE;
                        end
                    end
                end
            end
            rgb_led_pkg::ACT_MINUTE: begin
                n_count = (count_inc >= rgb_led_pkg::MINUTE_WRAP) ? '0 : count_inc[UW-1:0];
            end
            default: ;
        endcase

        // timer expiry, sleep expiry and lights-off flag
        if (n_mode == rgb_led_pkg::MODE_TIMER && n_count >= {1'b0, n_limit}) begin
            n_mode = rgb_led_pkg::MODE_PATTERN;
        end
        if (n_mode == rgb_led_pkg::MODE_SLEEP && n_count >= {1'b0, n_limit}) off = 1'b1;
        if (n_mode == rgb_led_pkg::MODE_SENSOR && bright) off = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_top    <= rgb_led_pkg::RST_FADE_TOP;
            r_fade_bottom <= rgb_led_pkg::RST_FADE_BOTTOM;
            r_dark_thr    <= rgb_led_pkg::RST_DARK_THR;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mode        <= rgb_led_pkg::RST_MODE;
            r_pattern     <= rgb_led_pkg::RST_PATTERN;
            r_colour      <= '0;
            r_falling     <= 1'b0;
            r_fade        <= '0;
            r_red         <= '0;
            r_green       <= '0;
            r_blue        <= '0;
            r_limit       <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (rgb_led_pkg::t_cfg_index'(i_cfg_index))
                    rgb_led_pkg::CFG_FADE_TOP:    r_fade_top    <= i_cfg_data[LW-1:0];
                    rgb_led_pkg::CFG_FADE_BOTTOM: r_fade_bottom <= i_cfg_data[LW-1:0];
                    rgb_led_pkg::CFG_DARK_THR:    r_dark_thr    <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_pattern   <= n_pattern;
                r_colour    <= n_colour;
                r_falling   <= n_falling;
                r_fade      <= n_fade;
                r_red       <= n_red;
                r_green     <= n_green;
                r_blue      <= n_blue;
                r_limit     <= n_limit;
                r_count     <= n_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_cmd    <= s_axis_tdata[7:0];
            r_in_light  <= s_axis_tdata[17:8];
        end
        if (advance) begin
            r_out_data <= {4'd0, n_mode, off, n_blue, n_green, n_red};
        end
    end

endmodule
